[hdl/ilist_pkg.sv]
// Shared types and codes for the indexed list: request and result layouts, codes, cell commands.
`default_nettype none

package ilist_pkg;

	// Operation codes carried in the request.
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_SET    = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	// Status codes returned with every result.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_INDEX = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_EMPTY = 2'd3;

	// Width of the external data fields.
	localparam int unsigned PORT_DATA_W = 32;

	typedef struct packed {
		logic [2:0]  operation;
		logic [5:0]  position;
		logic [31:0] element_in;
	} list_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] element_out;
		logic [6:0]  entry_total;
	} list_rsp_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef enum logic [1:0] {
		LS_IDLE,
		LS_EXEC,
		LS_GATHER,
		LS_RESP
	} list_state_t;

endpackage

`default_nettype wire

[hdl/ilist_cell.sv]
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
`default_nettype none

module ilist_cell
	import ilist_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned CNT_W      = 7,
	parameter int unsigned INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire cell_op_t              op,
	input  wire logic [CNT_W-1:0]      tgt,
	input  wire logic [DATA_WIDTH-1:0] word,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	output logic      [DATA_WIDTH-1:0] data
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  at_tgt;
	logic                  above_tgt;

	assign at_tgt    = (tgt == MY_IDX);
	assign above_tgt = (MY_IDX > tgt);

	always_comb begin
		data_d = data_q;
		unique case (op)
			CELL_WRITE: begin
				if (at_tgt) begin
					data_d = word;
				end
			end
			CELL_SHIFT_UP: begin
				// Entries above the insert point move up by one place.
				if (at_tgt) begin
					data_d = word;
				end else if (above_tgt) begin
					data_d = left_data;
				end
			end
			CELL_SHIFT_DOWN: begin
				// The removed entry and everything above it take the next entry.
				if (at_tgt || above_tgt) begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

[hdl/indexed_list_insert_remove_top.sv]
// Top level of the indexed list: request decode, cell chain, read gather and result register.
`default_nettype none

// Fixed-capacity ordered list of data words, built as a chain of CAPACITY cells that each hold
// one entry. Every request (append, insert, set, get, remove) yields exactly one result with a
// status and the entry count after the operation. Insert and remove move all later entries by
// one place together, because every cell loads from its left or right neighbor at once.
// After acceptance, a request is checked in the EXEC state, where the cells are updated and
// the addressed entry is picked out of groups of eight cells into registers. In the GATHER
// state those groups are combined into the result register, which is offered in the RESP
// state. The next request is accepted in the same cycle the result is taken, so the block
// takes no new request before the previous result has been handed over. Words
// are kept to their low DATA_WIDTH bits, and the result word is the low 32 bits of the entry.
// Positions are six bits wide, so only the first 64 entries can be addressed directly. Entries
// above the count hold whatever was last moved into them and are never returned.
module indexed_list_insert_remove_top
	import ilist_pkg::*;
#(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire list_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output list_rsp_t      rsp
);

	// Count width holds the value CAPACITY itself.
	localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
	// Comparisons between the six-bit position and the count run at this width.
	localparam int unsigned CMP_W       = (CNT_W > 6) ? CNT_W : 6;
	localparam int unsigned WIDE_W      = (DATA_WIDTH > PORT_DATA_W) ? DATA_WIDTH : PORT_DATA_W;
	localparam int unsigned GRP         = 8;
	localparam int unsigned READ_CELLS  = (CAPACITY < 64) ? CAPACITY : 64;
	localparam int unsigned READ_GROUPS = (READ_CELLS + GRP - 1) / GRP;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	list_state_t state_q;
	list_state_t state_d;

	list_req_t        req_q;
	logic [CNT_W-1:0] count_q;

	// Decode of the held request against the current count.
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic                  list_full;
	logic [1:0]            status_d;
	cell_op_t              cell_op;
	logic [CNT_W-1:0]      cell_tgt;
	logic [CNT_W-1:0]      count_d;
	logic                  rd_en;
	logic [WIDE_W-1:0]     word_wide;
	logic [DATA_WIDTH-1:0] word;

	// Read path.
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] grp_d     [READ_GROUPS];
	logic [DATA_WIDTH-1:0] grp_s1    [READ_GROUPS];
	logic [1:0]            status_s1;
	logic [DATA_WIDTH-1:0] gather;
	logic [WIDE_W-1:0]     gather_wide;
	list_rsp_t             rsp_q;

	logic exec_active;
	logic accept;

	// ------------------------------------------------------------------
	// Control state machine
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LS_IDLE: begin
				if (req_valid) begin
					state_d = LS_EXEC;
				end
			end
			LS_EXEC: begin
				state_d = LS_GATHER;
			end
			LS_GATHER: begin
				state_d = LS_RESP;
			end
			LS_RESP: begin
				// A new request may enter in the same cycle the result leaves.
				if (rsp_ready) begin
					state_d = req_valid ? LS_EXEC : LS_IDLE;
				end
			end
			default: begin
				state_d = LS_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		rsp_valid   = 1'b0;
		exec_active = 1'b0;
		unique case (state_q)
			LS_IDLE: begin
				req_ready = 1'b1;
			end
			LS_EXEC: begin
				exec_active = 1'b1;
			end
			LS_GATHER: begin
				req_ready = 1'b0;
			end
			LS_RESP: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (exec_active) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// ------------------------------------------------------------------
	// Request check and cell command
	// ------------------------------------------------------------------
	assign pos_ext   = CMP_W'(req_q.position);
	assign cnt_ext   = CMP_W'(count_q);
	assign list_full = (count_q == CNT_FULL);
	assign word_wide = WIDE_W'(req_q.element_in);
	assign word      = word_wide[DATA_WIDTH-1:0];

	always_comb begin
		status_d = STATUS_OK;
		cell_op  = CELL_HOLD;
		cell_tgt = count_q;
		count_d  = count_q;
		rd_en    = 1'b0;
		case (req_q.operation)
			OP_APPEND: begin
				if (list_full) begin
					status_d = STATUS_FULL;
				end else begin
					cell_op  = CELL_WRITE;
					cell_tgt = count_q;
					count_d  = count_q + CNT_ONE;
				end
			end
			OP_INSERT: begin
				// The index check takes priority over the full check.
				if (pos_ext > cnt_ext) begin
					status_d = STATUS_INDEX;
				end else if (list_full) begin
					status_d = STATUS_FULL;
				end else begin
					cell_op  = CELL_SHIFT_UP;
					cell_tgt = CNT_W'(pos_ext);
					count_d  = count_q + CNT_ONE;
				end
			end
			OP_SET: begin
				if (pos_ext >= cnt_ext) begin
					status_d = STATUS_INDEX;
				end else begin
					cell_op  = CELL_WRITE;
					cell_tgt = CNT_W'(pos_ext);
					rd_en    = 1'b1;
				end
			end
			OP_GET: begin
				if (pos_ext >= cnt_ext) begin
					status_d = STATUS_INDEX;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					status_d = STATUS_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = STATUS_INDEX;
				end else begin
					cell_op  = CELL_SHIFT_DOWN;
					cell_tgt = CNT_W'(pos_ext);
					count_d  = count_q - CNT_ONE;
					rd_en    = 1'b1;
				end
			end
			default: begin
				// Unused codes leave everything as it is and report success.
				status_d = STATUS_OK;
			end
		endcase
		if (!exec_active) begin
			cell_op = CELL_HOLD;
			rd_en   = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Cell chain
	// ------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		// The end cells feed themselves where no neighbor exists.
		if (i == 0) begin : g_first
			assign left_data = cell_data[i];
		end else begin : g_inner_left
			assign left_data = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner_right
			assign right_data = cell_data[i+1];
		end

		ilist_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.tgt        (cell_tgt),
			.word       (word),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i])
		);
	end

	// ------------------------------------------------------------------
	// Read gather: the addressed entry is picked within groups of eight
	// cells and registered before the cells change, then the groups are
	// combined in the next cycle.
	// ------------------------------------------------------------------
	always_comb begin
		for (int g = 0; g < READ_GROUPS; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if ((g * GRP + j < READ_CELLS) && rd_en
						&& (req_q.position == 6'(g * GRP + j))) begin
					grp_d[g] = grp_d[g] | cell_data[g * GRP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_active) begin
			for (int g = 0; g < READ_GROUPS; g++) begin
				grp_s1[g] <= grp_d[g];
			end
			status_s1 <= status_d;
		end
	end

	always_comb begin
		gather = '0;
		for (int g = 0; g < READ_GROUPS; g++) begin
			gather = gather | grp_s1[g];
		end
	end

	assign gather_wide = WIDE_W'(gather);

	// Result register; the count has already been updated when this loads.
	always_ff @(posedge clk) begin
		if (state_q == LS_GATHER) begin
			rsp_q.status      <= status_s1;
			rsp_q.element_out <= gather_wide[PORT_DATA_W-1:0];
			rsp_q.entry_total <= 7'(count_q);
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the indexed list: directed, capacity, random and stall tests.
`default_nettype none

// The testbench keeps its own copy of the list contents and the entry count. Every request
// that the block accepts is applied to that copy at the acceptance edge, and the result it
// should produce is queued. A separate checker pops the oldest queued result whenever the
// block hands one over and compares it field by field. The tests run in turn: a short
// directed sweep of the corner cases, a fill-to-capacity test, three random phases with
// different idle patterns on the request and result sides, and a long result stall that
// backs the block up.
module testbench;
	import ilist_pkg::*;

	localparam int unsigned LIST_CAP = 64;
	localparam int unsigned WORD_W   = 32;
	localparam logic [31:0] WORD_MASK = (WORD_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WORD_W) - 32'd1);

	// Operation codes above remove are left unused by the block.
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	// Length of the forced stall on the result side, in clock cycles.
	localparam int unsigned LONG_HOLD_CYCLES = 300;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	list_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	list_rsp_t rsp;

	// Testbench copy of the list state.
	logic [31:0] mirror_words [LIST_CAP];
	int unsigned mirror_count = 0;

	// Results the block still owes, oldest first.
	list_rsp_t pending_results [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned holds_asked   = 0;
	int unsigned holds_served  = 0;
	int unsigned fail_count    = 0;
	bit          growing       = 1'b1;

	indexed_list_insert_remove_top #(
		.CAPACITY  (LIST_CAP),
		.DATA_WIDTH(WORD_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Applies one request to the list copy and returns the result the block must give.
	function automatic list_rsp_t apply_list_op(input list_req_t r);
		list_rsp_t   res;
		logic [31:0] word;
		int unsigned k;
		res = '0;
		res.status = STATUS_OK;
		word = r.element_in & WORD_MASK;
		case (r.operation)
			OP_APPEND: begin
				if (mirror_count >= LIST_CAP) begin
					res.status = STATUS_FULL;
				end else begin
					mirror_words[mirror_count] = word;
					mirror_count++;
				end
			end
			OP_INSERT: begin
				// The index check takes priority over the full check.
				if (r.position > mirror_count) begin
					res.status = STATUS_INDEX;
				end else if (mirror_count >= LIST_CAP) begin
					res.status = STATUS_FULL;
				end else begin
					for (k = mirror_count; k > r.position; k--)
						mirror_words[k] = mirror_words[k - 1];
					mirror_words[r.position] = word;
					mirror_count++;
				end
			end
			OP_SET: begin
				if (r.position >= mirror_count) begin
					res.status = STATUS_INDEX;
				end else begin
					res.element_out = mirror_words[r.position];
					mirror_words[r.position] = word;
				end
			end
			OP_GET: begin
				if (r.position >= mirror_count) begin
					res.status = STATUS_INDEX;
				end else begin
					res.element_out = mirror_words[r.position];
				end
			end
			OP_REMOVE: begin
				if (mirror_count == 0) begin
					res.status = STATUS_EMPTY;
				end else if (r.position >= mirror_count) begin
					res.status = STATUS_INDEX;
				end else begin
					res.element_out = mirror_words[r.position];
					for (k = r.position; k + 1 < mirror_count; k++)
						mirror_words[k] = mirror_words[k + 1];
					mirror_count--;
				end
			end
			default: begin
				// Spare codes leave everything as it is.
			end
		endcase
		res.entry_total = 7'(mirror_count);
		return res;
	endfunction

	// Offers one request and returns at the edge where it is accepted. The request side
	// idles first for a random number of cycles according to send_idle_pct. When no idle
	// cycle is drawn, valid simply stays high from the previous request.
	task automatic send_request(input logic [2:0] op, input logic [5:0] pos,
			input logic [31:0] word);
		list_req_t item;
		item.operation  = op;
		item.position   = pos;
		item.element_in = word;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_results.push_back(apply_list_op(item));
	endtask

	// Draws one request that mostly makes sense for the current list. While the list is
	// growing, appends and inserts dominate. While it is shrinking, removes dominate. The
	// direction flips at full and at empty, so the random phases pass through both ends.
	task automatic send_random_request();
		int unsigned pick;
		logic [2:0]  op;
		logic [5:0]  pos;
		if (mirror_count >= LIST_CAP)
			growing = 1'b0;
		else if (mirror_count == 0)
			growing = 1'b1;
		pick = $urandom_range(99);
		if (growing) begin
			if (pick < 30)      op = OP_APPEND;
			else if (pick < 55) op = OP_INSERT;
			else if (pick < 70) op = OP_SET;
			else if (pick < 85) op = OP_GET;
			else if (pick < 96) op = OP_REMOVE;
			else                op = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
		end else begin
			if (pick < 8)       op = OP_APPEND;
			else if (pick < 16) op = OP_INSERT;
			else if (pick < 31) op = OP_SET;
			else if (pick < 46) op = OP_GET;
			else if (pick < 96) op = OP_REMOVE;
			else                op = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
		end
		// Most positions land where the operation succeeds; the rest cover the full field.
		pos = 6'($urandom_range(63));
		if ($urandom_range(99) < 85) begin
			if (op == OP_INSERT)
				pos = 6'($urandom_range((mirror_count > 63) ? 63 : mirror_count));
			else if (mirror_count > 0)
				pos = 6'($urandom_range(mirror_count - 1));
		end
		send_request(op, pos, $urandom());
	endtask

	// Short sweep of the corner cases: remove, get, set and insert on an empty list, insert past and
	// at the count, set and get and remove out of range, extreme words and positions, and the
	// spare operation codes.
	task automatic test_directed();
		send_request(OP_REMOVE, 6'd0,  32'h0000_0000);
		send_request(OP_GET,    6'd0,  32'h0000_0000);
		send_request(OP_SET,    6'd5,  32'hFFFF_FFFF);
		send_request(OP_INSERT, 6'd1,  32'h1111_1111);
		send_request(OP_INSERT, 6'd0,  32'hFFFF_FFFF);
		send_request(OP_APPEND, 6'd63, 32'h0000_0000);
		send_request(OP_APPEND, 6'd0,  32'hA5A5_A5A5);
		send_request(OP_INSERT, 6'd3,  32'h5A5A_5A5A);
		send_request(OP_INSERT, 6'd1,  32'h1234_5678);
		send_request(OP_GET,    6'd4,  32'h0000_0000);
		send_request(OP_GET,    6'd5,  32'h0000_0000);
		send_request(OP_SET,    6'd0,  32'h0000_0000);
		send_request(OP_SET,    6'd5,  32'hDEAD_BEEF);
		send_request(OP_REMOVE, 6'd5,  32'h0000_0000);
		send_request(OP_REMOVE, 6'd63, 32'h0000_0000);
		send_request(OP_GET,    6'd63, 32'h0000_0000);
		send_request(OP_REMOVE, 6'd1,  32'h0000_0000);
		send_request(OP_SPARE_A, 6'd63, 32'hFFFF_FFFF);
		send_request(OP_SPARE_B, 6'd0,  32'hFFFF_FFFF);
		send_request(OP_SPARE_C, 6'd2,  32'h0000_0000);
		send_request(OP_REMOVE, 6'd3,  32'h0000_0000);
		send_request(OP_REMOVE, 6'd0,  32'h0000_0000);
		send_request(OP_REMOVE, 6'd0,  32'h0000_0000);
		send_request(OP_REMOVE, 6'd0,  32'h0000_0000);
		send_request(OP_REMOVE, 6'd0,  32'h0000_0000);
	endtask

	// Fills the list to capacity, checks that growth is refused while the last entry stays
	// reachable, then empties it again by removing at random positions.
	task automatic test_capacity();
		while (mirror_count < LIST_CAP) begin
			if ($urandom_range(1))
				send_request(OP_APPEND, 6'($urandom_range(63)), $urandom());
			else
				send_request(OP_INSERT, 6'($urandom_range((mirror_count > 63) ? 63 : mirror_count)),
					$urandom());
		end
		send_request(OP_APPEND, 6'd0,  32'hFFFF_FFFF);
		send_request(OP_INSERT, 6'd63, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 6'd0,  32'h0000_0000);
		send_request(OP_GET,    6'd63, 32'h0000_0000);
		send_request(OP_SET,    6'd63, 32'hFFFF_FFFF);
		send_request(OP_REMOVE, 6'd63, 32'h0000_0000);
		send_request(OP_INSERT, 6'd63, 32'h8000_0001);
		while (mirror_count > 0)
			send_request(OP_REMOVE, 6'($urandom_range(mirror_count - 1)), $urandom());
	endtask

	task automatic test_random(input int unsigned count, input int unsigned send_pct,
			input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_random_request();
	endtask

	// Stops the result side for a long stretch while requests keep coming, so the block
	// has to hold its result and refuse further requests until the stall ends.
	task automatic test_result_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holds_asked++;
		repeat (16)
			send_random_request();
	endtask

	// Result side ready: random idling, or a long hold when a test asks for one.
	initial begin : ready_driver
		int unsigned n;
		forever begin
			@(posedge clk);
			if (holds_served < holds_asked) begin
				rsp_ready <= 1'b0;
				for (n = 1; n < LONG_HOLD_CYCLES; n++)
					@(posedge clk);
				holds_served++;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every handed-over result is compared against the oldest owed result.
	always @(posedge clk) begin : result_checker
		list_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d element_out %h total %0d",
					rsp.status, rsp.element_out, rsp.entry_total);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.element_out !== want.element_out) begin
					$error("element_out mismatch: expected %h, actual %h",
						want.element_out, rsp.element_out);
					fail_count++;
				end
				if (rsp.entry_total !== want.entry_total) begin
					$error("entry_total mismatch: expected %0d, actual %0d",
						want.entry_total, rsp.entry_total);
					fail_count++;
				end
			end
		end
	end

	initial begin : test_sequence
		int unsigned waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 80;
		test_directed();
		test_capacity();
		test_random(650, 37, 80);
		test_random(650, 80, 37);
		test_random(650, 0, 0);
		test_result_stall();
		req_valid <= 1'b0;

		// Wait for the block to hand over everything it owes, then a few cycles more so
		// that any stray result would still be caught.
		waited = 0;
		while (pending_results.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("** indexed_list_insert_remove_top: PASSED **");
		else
			$display("** indexed_list_insert_remove_top: FAILED **");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#4_000_000;
		$display("** indexed_list_insert_remove_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
